FILE: rtl/core/streaming_velocity_min_timestep_top_defines.svh
// Assertion macros for the streaming velocity minimum time step block.
`ifndef STREAMING_VELOCITY_MIN_TIMESTEP_TOP_DEFINES_SVH
`define STREAMING_VELOCITY_MIN_TIMESTEP_TOP_DEFINES_SVH

// Checks that cond holds in the same cycle as trig.
`define SVMT_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("Same-cycle check failed.");

// Checks that cond holds in the cycle after trig.
`define SVMT_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("Next-cycle check failed.");

`endif

FILE: rtl/core/svmt_pkg.sv
// Shared types and constants of the streaming velocity minimum time step block.
`timescale 1ns / 1ps
`default_nettype none
package svmt_pkg;
    localparam int WORD_WIDTH    = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_FACTOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABILITY_FACTOR = 2'd2;

    typedef struct packed {
        logic [WORD_WIDTH-1:0]        density;
        logic signed [WORD_WIDTH-1:0] field_x;
        logic signed [WORD_WIDTH-1:0] field_y;
        logic signed [WORD_WIDTH-1:0] field_z;
        logic                         last_cell;
    } t_cell_in;

    typedef struct packed {
        logic [WORD_WIDTH-1:0] min_time_step;
        logic                  saturated;
    } t_step_out;

    typedef struct packed {
        logic [WORD_WIDTH-1:0] density;
        logic [WORD_WIDTH-1:0] mag_x;
        logic [WORD_WIDTH-1:0] mag_y;
        logic [WORD_WIDTH-1:0] mag_z;
        logic                  b2_zero;
        logic                  last_cell;
    } t_cell_cls;

    typedef struct packed {
        logic [WORD_WIDTH-1:0] cell_width;
        logic [WORD_WIDTH-1:0] velocity_factor;
        logic [WORD_WIDTH-1:0] stability_factor;
    } t_cfg;
endpackage
`default_nettype wire

FILE: rtl/core/streaming_velocity_min_timestep_top.sv
// Top level of the streaming velocity minimum time step block.
//
//   Channel   Handshake              Payload
//   cells     push / full            i_cell   (svmt_pkg::t_cell_in)
//   results   pop / empty            o_result (svmt_pkg::t_step_out)
//   config    i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A cell runs through the back sequencer in order: three squares, a division
// of Q = 2W+2+F dividend bits, a root of S = ceil(Q/2) bits, two products and
// a division of N = W+3F quotient bits (W word width), on the shared shift-add
// and divide unit. Cells with a zero field, factor or density go straight to done.
// The queue takes two cells while the back is busy; a result waits in the output
// register until popped, and the back stalls only on a last cell while it is held.
// Reset is synchronous and active low and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "streaming_velocity_min_timestep_top_defines.svh"
module streaming_velocity_min_timestep_top #(
    parameter int FRAC_BITS = svmt_pkg::FRAC_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   push,
    output logic                                  full,
    input  svmt_pkg::t_cell_in                    i_cell,
    input  wire                                   pop,
    output logic                                  empty,
    output svmt_pkg::t_step_out                   o_result,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [svmt_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [svmt_pkg::WORD_WIDTH-1:0]        i_cfg_data
);
    localparam int W = svmt_pkg::WORD_WIDTH;

    svmt_pkg::t_cfg      r_cfg;
    svmt_pkg::t_cell_cls front_cls;
    svmt_pkg::t_cell_cls q_head;
    logic                q_empty;
    logic                q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_width       <= W'(1) << FRAC_BITS;
            r_cfg.velocity_factor  <= W'(1) << FRAC_BITS;
            r_cfg.stability_factor <= W'(1) << FRAC_BITS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                svmt_pkg::CFG_CELL_WIDTH:       r_cfg.cell_width       <= i_cfg_data;
                svmt_pkg::CFG_VELOCITY_FACTOR:  r_cfg.velocity_factor  <= i_cfg_data;
                svmt_pkg::CFG_STABILITY_FACTOR: r_cfg.stability_factor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    svmt_front u_front (
        .i_cell (i_cell),
        .o_cls  (front_cls)
    );

    svmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    svmt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_item    (q_head),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

    `SVMT_ASSERT_SAME(a_sat_flag, i_clk, i_rst_n, !empty, o_result.saturated == (o_result.min_time_step == '1))
    `SVMT_ASSERT_SAME(a_pop_nonempty, i_clk, i_rst_n, q_pop, !q_empty)
    `SVMT_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, push && !full, !q_empty)
endmodule
`default_nettype wire

FILE: rtl/core/svmt_front.sv
// Front stage: takes field magnitudes and flags a zero field.
`timescale 1ns / 1ps
`default_nettype none
module svmt_front (
    input  svmt_pkg::t_cell_in  i_cell,
    output svmt_pkg::t_cell_cls o_cls
);
    localparam int W = svmt_pkg::WORD_WIDTH;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    always_comb begin
        o_cls.density   = i_cell.density;
        o_cls.mag_x     = mag(i_cell.field_x);
        o_cls.mag_y     = mag(i_cell.field_y);
        o_cls.mag_z     = mag(i_cell.field_z);
        o_cls.b2_zero   = (i_cell.field_x == '0) && (i_cell.field_y == '0)
                          && (i_cell.field_z == '0);
        o_cls.last_cell = i_cell.last_cell;
    end
endmodule
`default_nettype wire

FILE: rtl/core/svmt_queue.sv
// Short queue of classified cells between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module svmt_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  svmt_pkg::t_cell_cls i_data,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_empty,
    output svmt_pkg::t_cell_cls o_data
);
    localparam int D  = svmt_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    svmt_pkg::t_cell_cls r_mem [D];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(D));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr] <= i_data;
                r_wr <= (r_wr == PW'(D - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(D - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/svmt_back.sv
// Back sequencer: serial squares, division, root, products, and the running minimum.
`timescale 1ns / 1ps
`default_nettype none
module svmt_back #(
    parameter int FRAC_BITS = svmt_pkg::FRAC_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  svmt_pkg::t_cfg      i_cfg,
    input  wire                 i_q_empty,
    output logic                o_q_pop,
    input  svmt_pkg::t_cell_cls i_item,
    output logic                o_empty,
    input  wire                 i_pop,
    output svmt_pkg::t_step_out o_result
);
    localparam int W    = svmt_pkg::WORD_WIDTH;
    localparam int BW   = 2 * W + 2;
    localparam int QW   = BW + FRAC_BITS;
    localparam int SW   = (QW + 1) / 2;
    localparam int DW   = 2 * W + SW + 1;
    localparam int NW2  = W + 3 * FRAC_BITS;
    localparam int NMAX = (2 * SW > NW2) ? 2 * SW : NW2;
    localparam int CMAX = (QW > NW2) ? QW : NW2;
    localparam int CW   = $clog2(CMAX + 1);
    localparam logic [W-1:0] MAX_EST = '1;

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_DIV1, S_SQRT, S_MUL1, S_MUL2, S_DIV2, S_DONE
    } t_state;

    t_state              r_state;
    svmt_pkg::t_cell_cls r_item;
    logic [CW-1:0]       r_cnt;
    logic [1:0]          r_comp;
    logic [DW-1:0]       r_acc;
    logic [DW-1:0]       r_mc;
    logic [SW-1:0]       r_mp;
    logic [NMAX-1:0]     r_n;
    logic [DW-1:0]       r_r;
    logic [DW-1:0]       r_dv;
    logic [SW-1:0]       r_rt;
    logic [SW:0]         r_sr;
    logic [W-1:0]        r_est;
    logic [W-1:0]        r_min;
    logic                r_out_valid;
    svmt_pkg::t_step_out r_out;

    logic [DW-1:0]   mul_sum;
    logic [DW:0]     div_t;
    logic [DW:0]     div_d;
    logic            div_ge;
    logic [DW-1:0]   div_r;
    logic [NMAX-1:0] div_n;
    logic [SW+2:0]   sq_t;
    logic [SW+2:0]   sq_trial;
    logic [SW+2:0]   sq_d;
    logic            sq_ge;
    logic [SW:0]     sq_r;
    logic [SW-1:0]   sq_rt;
    logic [NMAX-1:0] sq_n;
    logic            last_step;
    logic [NW2-1:0]  q2;
    logic [W-1:0]    new_min;
    logic [W-1:0]    next_mag;

    always_comb begin
        mul_sum   = r_acc + (r_mp[0] ? r_mc : '0);
        div_t     = {r_r, r_n[NMAX-1]};
        div_d     = div_t - {1'b0, r_dv};
        div_ge    = (div_t >= {1'b0, r_dv});
        div_r     = div_ge ? div_d[DW-1:0] : div_t[DW-1:0];
        div_n     = {r_n[NMAX-2:0], div_ge};
        sq_t      = {r_sr, r_n[NMAX-1 -: 2]};
        sq_trial  = {1'b0, r_rt, 2'b01};
        sq_d      = sq_t - sq_trial;
        sq_ge     = (sq_t >= sq_trial);
        sq_r      = sq_ge ? sq_d[SW:0] : sq_t[SW:0];
        sq_rt     = {r_rt[SW-2:0], sq_ge};
        sq_n      = {r_n[NMAX-3:0], 2'b00};
        last_step = (r_cnt == CW'(1));
        q2        = div_n[NW2-1:0];
        new_min   = (r_est < r_min) ? r_est : r_min;
        next_mag  = (r_comp == 2'd0) ? r_item.mag_y : r_item.mag_z;
    end

    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min       <= MAX_EST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_item <= i_item;
                        r_acc  <= '0;
                        r_mc   <= DW'(i_item.mag_x);
                        r_mp   <= SW'(i_item.mag_x);
                        r_cnt  <= CW'(W);
                        r_comp <= 2'd0;
                        if (i_item.b2_zero || i_cfg.velocity_factor == '0
                            || i_cfg.stability_factor == '0) begin
                            r_est   <= MAX_EST;
                            r_state <= S_DONE;
                        end else if (i_item.density == '0) begin
                            r_est   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    r_acc <= mul_sum;
                    r_mc  <= {r_mc[DW-2:0], 1'b0};
                    r_mp  <= {1'b0, r_mp[SW-1:1]};
                    r_cnt <= r_cnt - CW'(1);
                    if (last_step) begin
                        if (r_comp == 2'd2) begin
                            r_n     <= NMAX'(mul_sum[BW-1:0]) << (NMAX - BW);
                            r_r     <= '0;
                            r_dv    <= DW'(r_item.density);
                            r_cnt   <= CW'(QW);
                            r_state <= S_DIV1;
                        end else begin
                            r_mc   <= DW'(next_mag);
                            r_mp   <= SW'(next_mag);
                            r_cnt  <= CW'(W);
                            r_comp <= r_comp + 2'd1;
                        end
                    end
                end
                S_DIV1: begin
                    r_n   <= div_n;
                    r_r   <= div_r;
                    r_cnt <= r_cnt - CW'(1);
                    if (last_step) begin
                        r_n     <= NMAX'(div_n[QW-1:0]) << (NMAX - 2 * SW);
                        r_rt    <= '0;
                        r_sr    <= '0;
                        r_cnt   <= CW'(SW);
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_n   <= sq_n;
                    r_sr  <= sq_r;
                    r_rt  <= sq_rt;
                    r_cnt <= r_cnt - CW'(1);
                    if (last_step) begin
                        if (sq_rt == '0) begin
                            r_est   <= MAX_EST;
                            r_state <= S_DONE;
                        end else begin
                            r_acc   <= '0;
                            r_mc    <= DW'(i_cfg.stability_factor);
                            r_mp    <= SW'(i_cfg.velocity_factor);
                            r_cnt   <= CW'(W);
                            r_state <= S_MUL1;
                        end
                    end
                end
                S_MUL1: begin
                    r_acc <= mul_sum;
                    r_mc  <= {r_mc[DW-2:0], 1'b0};
                    r_mp  <= {1'b0, r_mp[SW-1:1]};
                    r_cnt <= r_cnt - CW'(1);
                    if (last_step) begin
                        r_acc   <= '0;
                        r_mc    <= mul_sum;
                        r_mp    <= r_rt;
                        r_cnt   <= CW'(SW);
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    r_acc <= mul_sum;
                    r_mc  <= {r_mc[DW-2:0], 1'b0};
                    r_mp  <= {1'b0, r_mp[SW-1:1]};
                    r_cnt <= r_cnt - CW'(1);
                    if (last_step) begin
                        r_n     <= NMAX'(i_cfg.cell_width) << (NMAX - W);
                        r_r     <= '0;
                        r_dv    <= {mul_sum[DW-2:0], 1'b0};
                        r_cnt   <= CW'(NW2);
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    r_n   <= div_n;
                    r_r   <= div_r;
                    r_cnt <= r_cnt - CW'(1);
                    if (last_step) begin
                        r_est   <= (|q2[NW2-1:W]) ? MAX_EST : q2[W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_item.last_cell) begin
                        r_min   <= new_min;
                        r_state <= S_IDLE;
                    end else if (!r_out_valid || i_pop) begin
                        r_out.min_time_step <= new_min;
                        r_out.saturated     <= (new_min == MAX_EST);
                        r_out_valid         <= 1'b1;
                        r_min               <= MAX_EST;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
